// ----- design/cgs_pkg.sv -----
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types and constants for the color gradient sampler.
// ----------------------------------------------------------------------------
package cgs_pkg;

   localparam int MAX_STOPS_DEFAULT = 8;
   localparam int CHAN_W            = 16;
   localparam int NUM_CHAN          = 4;
   localparam int COLOR_W           = CHAN_W * NUM_CHAN;
   localparam int ENTRY_W           = CHAN_W + COLOR_W;   // {color, pos}
   localparam int IDX_W             = 3;
   localparam int COUNT_W           = 4;
   localparam int QUEUE_DEPTH       = 2;
   localparam int LEVEL_W           = 2;
   localparam int QUO_W             = CHAN_W + 1;         // local in 0..65536

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [IDX_W-1:0]      stop_index;
      logic [CHAN_W-1:0]     stop_pos;
      logic [COLOR_W-1:0]    stop_color;   // alpha, blue, green, red (red lowest)
      logic [CHAN_W-1:0]     sample_pos;
   } item_type;

   typedef struct packed {
      logic                  valid;
      logic [LEVEL_W-1:0]    level;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK0,
      ST_CHKL,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_OUT
   } state_type;

endpackage

// ----- design/cgs_ram.sv -----
// ----------------------------------------------------------------------------
// cgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cgs_front.sv -----
// ----------------------------------------------------------------------------
// cgs_front
// Accepts request transactions, unpacks them and holds them in a short queue.
// ----------------------------------------------------------------------------
module cgs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [103:0]              req_tdata,
   input  logic                      req_tuser,
   input  logic                      q_pop,
   output cgs_pkg::item_type         q_item,
   output cgs_pkg::queue_status_type q_status
);

   cgs_pkg::item_type              slot_ff [cgs_pkg::QUEUE_DEPTH];
   cgs_pkg::item_type              item_in;
   logic                           wr_ptr_ff, wr_ptr_in;
   logic                           rd_ptr_ff, rd_ptr_in;
   logic [cgs_pkg::LEVEL_W-1:0]    level_ff, level_in;
   logic                           push;
   logic                           pop;

   // unpack and classify the incoming transaction
   always_comb begin
      item_in.func       = req_tuser;
      item_in.stop_index = req_tdata[2:0];
      item_in.stop_pos   = req_tdata[18:3];
      item_in.stop_color = req_tdata[82:19];
      item_in.sample_pos = (req_tuser == cgs_pkg::FUNC_SAMPLE) ? req_tdata[98:83] : '0;
   end

   assign req_tready = (level_ff != cgs_pkg::LEVEL_W'(cgs_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && (level_ff != '0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + cgs_pkg::LEVEL_W'(push) - cgs_pkg::LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign q_item         = slot_ff[rd_ptr_ff];
   assign q_status.valid = (level_ff != '0);
   assign q_status.level = level_ff;

endmodule

// ----- design/cgs_back.sv -----
// ----------------------------------------------------------------------------
// cgs_back
// Executes queued items: stop writes into the stop RAM, and samples through
// a scan, a bit-serial divider and a per-channel multiply sequence.
// ----------------------------------------------------------------------------
module cgs_back #(
   parameter int MAX_STOPS = cgs_pkg::MAX_STOPS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cgs_pkg::queue_status_type        q_status,
   input  cgs_pkg::item_type                q_item,
   output logic                             q_pop,
   input  logic [cgs_pkg::COUNT_W-1:0]      stop_count,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cgs_pkg::COLOR_W-1:0]      rsp_tdata,
   output logic                             busy
);

   localparam int AW = $clog2(MAX_STOPS);
   localparam int NW = $clog2(MAX_STOPS + 1);
   localparam int CW = cgs_pkg::CHAN_W;
   localparam int PW = 2 * CW + 3;

   cgs_pkg::state_type               state_ff, state_in;
   logic [CW-1:0]                    t_ff, t_in;
   logic [cgs_pkg::ENTRY_W-1:0]      prev_ff, prev_in;
   logic [cgs_pkg::COLOR_W-1:0]      cur_ff, cur_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [CW:0]                      rem_ff, rem_in;
   logic [CW-1:0]                    span_ff, span_in;
   logic [cgs_pkg::QUO_W-1:0]        quo_ff, quo_in;
   logic [4:0]                       cnt_ff, cnt_in;
   logic [1:0]                       ch_ff, ch_in;
   logic signed [PW-1:0]             prod_ff, prod_in;
   logic [cgs_pkg::COLOR_W-1:0]      res_ff, res_in;

   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [AW-1:0]                    rd_addr;
   logic [cgs_pkg::ENTRY_W-1:0]      rd_data;
   logic [CW-1:0]                    rd_pos;
   logic [CW-1:0]                    prev_pos;
   logic [NW-1:0]                    n_stops;
   logic [AW-1:0]                    last_idx;
   logic [CW:0]                      cand;
   logic                             ge;
   logic [CW-1:0]                    chan_a;
   logic [CW-1:0]                    chan_b;
   logic signed [CW+1:0]             diff;

   cgs_ram #(
      .WIDTH (cgs_pkg::ENTRY_W),
      .DEPTH (MAX_STOPS)
   ) u_stop_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({q_item.stop_color, q_item.stop_pos}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign n_stops  = (32'(stop_count) > MAX_STOPS) ? NW'(MAX_STOPS) : NW'(stop_count);
   assign last_idx = AW'(n_stops - NW'(1));
   assign rd_pos   = rd_data[CW-1:0];
   assign prev_pos = prev_ff[CW-1:0];
   assign wr_addr  = AW'(q_item.stop_index);
   assign cand     = (cnt_ff == 5'd16) ? rem_ff : {rem_ff[CW-1:0], 1'b0};
   assign ge       = (cand >= {1'b0, span_ff});
   assign chan_a   = prev_ff[CW + 32'(ch_ff) * CW +: CW];
   assign chan_b   = cur_ff[32'(ch_ff) * CW +: CW];
   assign diff     = $signed({2'b00, chan_b}) - $signed({2'b00, chan_a});

   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      rem_in   = rem_ff;
      span_in  = span_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      ch_in    = ch_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      rd_addr  = '0;
      case (state_ff)
         cgs_pkg::ST_IDLE: begin
            if (q_status.valid) begin
               q_pop = 1'b1;
               if (q_item.func == cgs_pkg::FUNC_WRITE) begin
                  wr_en = (32'(q_item.stop_index) < MAX_STOPS);
               end else begin
                  t_in = q_item.sample_pos;
                  if (n_stops == '0) begin
                     res_in   = '0;
                     state_in = cgs_pkg::ST_OUT;
                  end else begin
                     state_in = cgs_pkg::ST_CHK0;
                  end
               end
            end
         end
         cgs_pkg::ST_CHK0: begin
            if (n_stops == NW'(1) || t_ff <= rd_pos) begin
               res_in   = rd_data[cgs_pkg::ENTRY_W-1:CW];
               state_in = cgs_pkg::ST_OUT;
            end else begin
               prev_in  = rd_data;
               rd_addr  = last_idx;
               state_in = cgs_pkg::ST_CHKL;
            end
         end
         cgs_pkg::ST_CHKL: begin
            if (t_ff >= rd_pos) begin
               res_in   = rd_data[cgs_pkg::ENTRY_W-1:CW];
               state_in = cgs_pkg::ST_OUT;
            end else begin
               rd_addr  = AW'(1);
               idx_in   = AW'(1);
               state_in = cgs_pkg::ST_SCAN;
            end
         end
         cgs_pkg::ST_SCAN: begin
            if (t_ff <= rd_pos || idx_ff == last_idx) begin
               cur_in = rd_data[cgs_pkg::ENTRY_W-1:CW];
               quo_in = '0;
               ch_in  = '0;
               if (rd_pos > prev_pos && t_ff >= prev_pos) begin
                  rem_in   = {1'b0, t_ff - prev_pos};
                  span_in  = rd_pos - prev_pos;
                  cnt_in   = 5'd16;
                  state_in = cgs_pkg::ST_DIV;
               end else begin
                  state_in = cgs_pkg::ST_MUL;
               end
            end else begin
               prev_in = rd_data;
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end
         cgs_pkg::ST_DIV: begin
            rem_in = ge ? (cand - {1'b0, span_ff}) : cand;
            quo_in = {quo_ff[cgs_pkg::QUO_W-2:0], ge};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = cgs_pkg::ST_MUL;
            end
         end
         cgs_pkg::ST_MUL: begin
            // both operands sign-extend to the product width
            prod_in  = diff * $signed({1'b0, quo_ff});
            state_in = cgs_pkg::ST_ADD;
         end
         cgs_pkg::ST_ADD: begin
            // floor divide by 65536 is an arithmetic shift; keep the low 16 bits
            res_in[32'(ch_ff) * CW +: CW] = chan_a + prod_ff[2*CW-1:CW];
            ch_in = ch_ff + 2'd1;
            state_in = (ch_ff == 2'd3) ? cgs_pkg::ST_OUT : cgs_pkg::ST_MUL;
         end
         cgs_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = cgs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cgs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      span_ff <= span_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      ch_ff   <= ch_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign rsp_tvalid = (state_ff == cgs_pkg::ST_OUT);
   assign rsp_tdata  = res_ff;
   assign busy       = (state_ff != cgs_pkg::ST_IDLE);

endmodule

// ----- design/color_gradient_sampler_core.sv -----
// ----------------------------------------------------------------------------
// color_gradient_sampler_core
// Piecewise-linear RGBA color ramp with a writable stop table.
// ----------------------------------------------------------------------------
// A request transaction either writes one gradient stop (tuser 0) or samples
// the ramp (tuser 1) and returns one RGBA color. Stops live in slots
// 0..stop_count-1 and are expected in ascending position order. Requests
// enter a two-entry queue, so the input keeps accepting, until the queue is
// full, while a result waits to be taken; a sequencer behind the queue
// executes one request at a time. A sample with no stops skips the search,
// and one that lands on an end stop returns that stop's color. Otherwise the
// sequencer scans 1 to MAX_STOPS-1 stops through the stop RAM's single read
// port, a bit-serial divider forms the local fraction, and a shared
// multiplier walks the four channels. The divider is skipped when the
// bracketing stops have a zero or negative span or the sample lies below the
// lower stop. The result then waits until rsp_tready takes it.
// ----------------------------------------------------------------------------
module color_gradient_sampler_core #(
   parameter int MAX_STOPS = cgs_pkg::MAX_STOPS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // tdata, low bit up: stop_index[3], stop_pos[16], stop_red[16],
   // stop_green[16], stop_blue[16], stop_alpha[16], sample_pos[16], zero pad[5]
   input  logic [103:0]                 req_tdata,
   // tuser: func (0 write stop, 1 sample)
   input  logic                         req_tuser,
   // response channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // tdata, low bit up: out_red[16], out_green[16], out_blue[16], out_alpha[16]
   output logic [63:0]                  rsp_tdata,
   // stop_count register
   input  logic                         csr_wr_en,
   input  logic [cgs_pkg::COUNT_W-1:0]  csr_wr_data
);

   cgs_pkg::item_type                q_item;
   cgs_pkg::queue_status_type        q_status;
   logic                             q_pop;
   logic                             back_busy;
   logic [cgs_pkg::COUNT_W-1:0]      stop_count_ff;

   // hold the stop count; software must write it only while the block is idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
      end else if (csr_wr_en) begin
         stop_count_ff <= csr_wr_data;
      end
   end

   // front: accept and unpack transactions, queue them
   cgs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .q_status   (q_status)
   );

   // back: write stops, or scan, divide and interpolate for a sample
   cgs_back #(
      .MAX_STOPS (MAX_STOPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .stop_count (stop_count_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .busy       (back_busy)
   );

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= cgs_pkg::LEVEL_W'(cgs_pkg::QUEUE_DEPTH))
      else $error("request queue overflow");

   // a pending response always belongs to an active sequencer
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> back_busy)
      else $error("response valid while sequencer idle");

   // after a response is taken the sequencer returns to idle first
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> !rsp_tvalid)
      else $error("response repeated");

   // a full queue must stall the request side
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (q_status.level == cgs_pkg::LEVEL_W'(cgs_pkg::QUEUE_DEPTH)) |-> !req_tready)
      else $error("ready while queue full");

endmodule
